// ===== rtl/core/sbe_pkg.sv =====
`default_nettype none

package sbe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int POOL_DEPTH  = 256;

    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
    localparam int POOL_AW  = $clog2(POOL_DEPTH);

    localparam int OPC_W  = 3;
    localparam int IDX_W  = 8;
    localparam int Q_W    = 32;
    localparam int STAT_W = 3;

    localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [IDX_W:0]   POOL_LIM   = POOL_DEPTH[IDX_W:0];

    // instruction codes
    localparam logic [OPC_W-1:0] OP_PUSH = 3'd1;
    localparam logic [OPC_W-1:0] OP_ADD  = 3'd2;
    localparam logic [OPC_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OPC_W-1:0] OP_MUL  = 3'd4;
    localparam logic [OPC_W-1:0] OP_SUB  = 3'd5;
    localparam logic [OPC_W-1:0] OP_RET  = 3'd6;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNDER   = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVER    = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADOP   = 3'd4;

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 48;
    localparam int STEP_W    = 6;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic             start;
        logic [OPC_W-1:0] opcode;
    } alu_ctl_t;

    typedef struct packed {
        logic           done;
        logic           sat;
        logic [Q_W-1:0] value;
    } alu_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbe_alu.sv =====
`default_nettype none

module sbe_alu (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire sbe_pkg::alu_ctl_t          ctl,
    input  wire logic [sbe_pkg::Q_W-1:0]    opa,
    input  wire logic [sbe_pkg::Q_W-1:0]    opb,
    output sbe_pkg::alu_rsp_t               rsp
);

    localparam logic [1:0] A_IDLE  = 2'd0;
    localparam logic [1:0] A_LOOP  = 2'd1;
    localparam logic [1:0] A_ROUND = 2'd2;
    localparam logic [1:0] A_CLAMP = 2'd3;

    logic [1:0]                 st_reg,   st_next;
    logic                       mul_reg,  mul_next;
    logic                       neg_reg,  neg_next;
    logic [sbe_pkg::STEP_W-1:0] cnt_reg,  cnt_next;
    logic [31:0]                hi_reg,   hi_next;
    logic [47:0]                lo_reg,   lo_next;
    logic [31:0]                opd_reg,  opd_next;
    logic [47:0]                mag_reg,  mag_next;
    logic [31:0]                val_reg,  val_next;
    logic                       sat_reg,  sat_next;
    logic                       done_reg, done_next;

    logic [31:0] mag_a, mag_b;
    logic [32:0] addsub;
    logic [32:0] msum;
    logic [33:0] trial;
    logic [47:0] prod_q;
    logic        rnd;

    assign mag_a  = opa[31] ? 32'(-opa) : opa;
    assign mag_b  = opb[31] ? 32'(-opb) : opb;
    assign addsub = (ctl.opcode == sbe_pkg::OP_SUB) ?
                    ({opa[31], opa} - {opb[31], opb}) :
                    ({opa[31], opa} + {opb[31], opb});
    assign msum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, opd_reg} : 33'd0);
    assign trial  = {1'b0, hi_reg, lo_reg[47]} - {2'b00, opd_reg};
    assign prod_q = {hi_reg, lo_reg[31:16]};
    assign rnd    = neg_reg && (lo_reg[15:0] != 16'd0);

    always_comb begin
        st_next   = st_reg;
        mul_next  = mul_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        opd_next  = opd_reg;
        mag_next  = mag_reg;
        val_next  = val_reg;
        sat_next  = sat_reg;
        done_next = 1'b0;
        unique case (st_reg)
            A_IDLE: begin
                if (ctl.start) begin
                    neg_next = opa[31] ^ opb[31];
                    hi_next  = 32'd0;
                    if (ctl.opcode == sbe_pkg::OP_MUL) begin
                        mul_next = 1'b1;
                        opd_next = mag_a;
                        lo_next  = {16'd0, mag_b};
                        cnt_next = sbe_pkg::STEP_W'(sbe_pkg::MUL_STEPS - 1);
                        st_next  = A_LOOP;
                    end else if (ctl.opcode == sbe_pkg::OP_DIV) begin
                        mul_next = 1'b0;
                        opd_next = mag_b;
                        lo_next  = {mag_a, 16'd0};
                        cnt_next = sbe_pkg::STEP_W'(sbe_pkg::DIV_STEPS - 1);
                        st_next  = A_LOOP;
                    end else begin
                        done_next = 1'b1;
                        if (addsub[32] != addsub[31]) begin
                            sat_next = 1'b1;
                            val_next = addsub[32] ? sbe_pkg::Q_MIN : sbe_pkg::Q_MAX;
                        end else begin
                            sat_next = 1'b0;
                            val_next = addsub[31:0];
                        end
                    end
                end
            end
            A_LOOP: begin
                if (mul_reg) begin
                    hi_next = msum[32:1];
                    lo_next = {16'd0, msum[0], lo_reg[31:1]};
                end else if (!trial[33]) begin
                    hi_next = trial[31:0];
                    lo_next = {lo_reg[46:0], 1'b1};
                end else begin
                    hi_next = {hi_reg[30:0], lo_reg[47]};
                    lo_next = {lo_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg - sbe_pkg::STEP_W'(1);
                if (cnt_reg == '0) begin
                    st_next = A_ROUND;
                end
            end
            A_ROUND: begin
                mag_next = mul_reg ? (prod_q + 48'(rnd)) : lo_reg;
                st_next  = A_CLAMP;
            end
            A_CLAMP: begin
                done_next = 1'b1;
                st_next   = A_IDLE;
                if (neg_reg) begin
                    sat_next = (mag_reg > 48'h0000_8000_0000);
                    val_next = sat_next ? sbe_pkg::Q_MIN : 32'(-mag_reg[31:0]);
                end else begin
                    sat_next = (mag_reg > 48'h0000_7FFF_FFFF);
                    val_next = sat_next ? sbe_pkg::Q_MAX : mag_reg[31:0];
                end
            end
            default: st_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= A_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        mul_reg <= mul_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        opd_reg <= opd_next;
        mag_reg <= mag_next;
        val_reg <= val_next;
        sat_reg <= sat_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.sat   = sat_reg;
    assign rsp.value = val_reg;

endmodule

`default_nettype wire

// ===== rtl/core/stack_bytecode_evaluator_unit.sv =====
// Multiply and divide use the shared shift-add / restoring unit, which retires one bit
// a cycle (32 multiplier bits, 48 quotient bits).
// One item at a time; s_tready is high only while the sequencer is idle, and a
// waiting result does not hold off the next item until that item needs the output register.
// Reset (aresetn low, synchronous) empties the stack and clears the saturation flag.
`default_nettype none

module stack_bytecode_evaluator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // opcode[2:0], const_index[10:3], pool_value[42:11]
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // result_value[31:0]
    output logic [3:0]       m_tuser    // status[2:0], saturated[3]
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUSH = 3'd1;
    localparam logic [2:0] S_RD_T = 3'd2;
    localparam logic [2:0] S_RD_S = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_RET  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]                        state_reg,  state_next;
    logic [sbe_pkg::CNT_W-1:0]         cnt_reg,    cnt_next;
    logic                              sat_reg,    sat_next;
    logic [sbe_pkg::OPC_W-1:0]         op_reg,     op_next;
    logic                              idx_ok_reg, idx_ok_next;
    logic [sbe_pkg::Q_W-1:0]           t_reg,      t_next;
    logic [sbe_pkg::Q_W-1:0]           hold_val_reg,  hold_val_next;
    logic [sbe_pkg::STAT_W-1:0]        hold_stat_reg, hold_stat_next;
    logic                              m_tvalid_reg;
    logic [31:0]                       m_tdata_reg;
    logic [3:0]                        m_tuser_reg;

    logic [sbe_pkg::Q_W-1:0]           stack_mem [sbe_pkg::STACK_DEPTH];
    logic [sbe_pkg::Q_W-1:0]           pool_mem  [sbe_pkg::POOL_DEPTH];
    logic [sbe_pkg::Q_W-1:0]           stack_rd_reg;
    logic [sbe_pkg::Q_W-1:0]           pool_rd_reg;

    logic                              stk_we;
    logic [sbe_pkg::STACK_AW-1:0]      stk_waddr;
    logic [sbe_pkg::Q_W-1:0]           stk_wdata;
    logic [sbe_pkg::STACK_AW-1:0]      stk_raddr;
    logic [sbe_pkg::CNT_W-1:0]         cnt_m1, cnt_m2;

    logic                              pool_we;
    logic                              in_mode;
    logic [sbe_pkg::OPC_W-1:0]         in_op;
    logic [sbe_pkg::IDX_W-1:0]         in_idx;
    logic [sbe_pkg::Q_W-1:0]           in_val;
    logic                              in_ok;
    logic                              accept;
    logic                              out_free;

    sbe_pkg::alu_ctl_t                 alu_ctl;
    sbe_pkg::alu_rsp_t                 alu_rsp;

    assign in_mode = s_tuser;
    assign in_op   = s_tdata[2:0];
    assign in_idx  = s_tdata[10:3];
    assign in_val  = s_tdata[42:11];
    assign in_ok   = ({1'b0, in_idx} < sbe_pkg::POOL_LIM);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign cnt_m1    = cnt_reg - sbe_pkg::CNT_W'(1);
    assign cnt_m2    = cnt_reg - sbe_pkg::CNT_W'(2);
    assign stk_raddr = (state_reg == S_RD_T) ? cnt_m2[sbe_pkg::STACK_AW-1:0]
                                             : cnt_m1[sbe_pkg::STACK_AW-1:0];
    assign pool_we   = accept && !in_mode && in_ok;

    sbe_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (alu_ctl),
        .opa     (stack_rd_reg),
        .opb     (t_reg),
        .rsp     (alu_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        op_next        = op_reg;
        idx_ok_next    = idx_ok_reg;
        t_next         = t_reg;
        hold_val_next  = hold_val_reg;
        hold_stat_next = hold_stat_reg;
        stk_we         = 1'b0;
        stk_waddr      = cnt_reg[sbe_pkg::STACK_AW-1:0];
        stk_wdata      = idx_ok_reg ? pool_rd_reg : '0;
        alu_ctl.start  = 1'b0;
        alu_ctl.opcode = op_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && in_mode) begin
                    op_next       = in_op;
                    idx_ok_next   = in_ok;
                    hold_val_next = '0;
                    unique case (in_op) inside
                        sbe_pkg::OP_PUSH: begin
                            if (cnt_reg == sbe_pkg::STACK_FULL) begin
                                hold_stat_next = sbe_pkg::ST_OVER;
                                state_next     = S_EMIT;
                            end else begin
                                state_next = S_PUSH;
                            end
                        end
                        sbe_pkg::OP_ADD, sbe_pkg::OP_SUB,
                        sbe_pkg::OP_MUL, sbe_pkg::OP_DIV: begin
                            if (cnt_reg < sbe_pkg::CNT_W'(2)) begin
                                hold_stat_next = sbe_pkg::ST_UNDER;
                                state_next     = S_EMIT;
                            end else begin
                                state_next = S_RD_T;
                            end
                        end
                        sbe_pkg::OP_RET: begin
                            if (cnt_reg == '0) begin
                                hold_stat_next = sbe_pkg::ST_UNDER;
                                state_next     = S_EMIT;
                            end else begin
                                state_next = S_RET;
                            end
                        end
                        default: begin
                            hold_stat_next = sbe_pkg::ST_BADOP;
                            state_next     = S_EMIT;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                stk_we     = 1'b1;
                cnt_next   = cnt_reg + sbe_pkg::CNT_W'(1);
                state_next = S_IDLE;
            end
            S_RD_T: begin
                t_next     = stack_rd_reg;
                state_next = S_RD_S;
            end
            S_RD_S: begin
                if (op_reg == sbe_pkg::OP_DIV && t_reg == '0) begin
                    hold_stat_next = sbe_pkg::ST_DIVZERO;
                    state_next     = S_EMIT;
                end else begin
                    alu_ctl.start = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (alu_rsp.done) begin
                    stk_we     = 1'b1;
                    stk_waddr  = cnt_m2[sbe_pkg::STACK_AW-1:0];
                    stk_wdata  = alu_rsp.value;
                    cnt_next   = cnt_m1;
                    sat_next   = sat_reg | alu_rsp.sat;
                    state_next = S_IDLE;
                end
            end
            S_RET: begin
                hold_val_next  = stack_rd_reg;
                hold_stat_next = sbe_pkg::ST_OK;
                state_next     = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cnt_next   = '0;
                    sat_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            sat_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
            if (state_reg == S_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (state_reg == S_EMIT && out_free) begin
            m_tdata_reg <= hold_val_reg;
            m_tuser_reg <= {sat_reg, hold_stat_reg};
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        idx_ok_reg    <= idx_ok_next;
        t_reg         <= t_next;
        hold_val_reg  <= hold_val_next;
        hold_stat_reg <= hold_stat_next;
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stack_rd_reg <= stack_mem[stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pool_we) begin
            pool_mem[in_idx[sbe_pkg::POOL_AW-1:0]] <= in_val;
        end
        pool_rd_reg <= pool_mem[in_idx[sbe_pkg::POOL_AW-1:0]];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= sbe_pkg::STACK_FULL)
        else $error("stack count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> state_reg == S_EXEC)
        else $error("arithmetic unit finished outside execute");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (alu_ctl.start && op_reg == sbe_pkg::OP_DIV) |-> t_reg != '0)
        else $error("divide started with zero divisor");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_free) |=> (m_tvalid && cnt_reg == '0 && !sat_reg))
        else $error("result issue did not clear stack and flag");

endmodule

`default_nettype wire
